// ===== hw/rtl/pmm_pkg.sv =====
// Shared constants, codes, state type and address helpers of the paged MMU.
package pmm_pkg;

   // Geometry
   localparam int NUM_PROCESSES = 4;
   localparam int NUM_FRAMES    = 4;
   localparam int PAGE_BYTES    = 16;
   localparam int TABLE_ENTRIES = 4;
   localparam int ENTRY_BYTES   = 4;
   localparam int MEM_BYTES     = NUM_FRAMES * PAGE_BYTES;

   // Field widths
   localparam int ACTION_W = 2;
   localparam int PID_W    = 2;
   localparam int VA_W     = 6;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 3;

   // Derived widths
   localparam int ADDR_W   = $clog2(MEM_BYTES);
   localparam int FRAME_W  = $clog2(NUM_FRAMES);
   localparam int OFFSET_W = $clog2(PAGE_BYTES);
   localparam int VPAGE_W  = VA_W - OFFSET_W;
   localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PROC_W   = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int BSEL_W   = $clog2(ENTRY_BYTES);
   localparam int SUM_W    = ADDR_W + 8;

   // Byte positions inside a table entry
   localparam logic [BSEL_W-1:0] BYTE_PAGE  = BSEL_W'(0);
   localparam logic [BSEL_W-1:0] BYTE_FRAME = BSEL_W'(1);
   localparam logic [BSEL_W-1:0] BYTE_PROT  = BSEL_W'(2);
   localparam logic [BSEL_W-1:0] BYTE_USE   = BSEL_W'(3);

   typedef enum logic [ACTION_W-1:0] {
      ACT_MAP   = 2'd0,
      ACT_STORE = 2'd1,
      ACT_LOAD  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_NO_TABLE     = 3'd1,
      ST_NO_ENTRY     = 3'd2,
      ST_WRITE_PROT   = 3'd3,
      ST_NO_MEMORY    = 3'd4,
      ST_TABLE_FULL   = 3'd5,
      ST_PROT_UPDATED = 3'd6,
      ST_BAD_PROT     = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_ALLOC,
      S_WRITE,
      S_SCAN_USE,
      S_SCAN_PAGE,
      S_SCAN_CHECK,
      S_MISS,
      S_HIT,
      S_HIT_FRAME,
      S_STORE_PROT,
      S_LOAD_DATA,
      S_RESPOND
   } state_type;

   // Physical address of one byte of a table entry, wrapped to memory size
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [FRAME_W-1:0] tf,
                                                    input logic [IDX_W-1:0]   idx,
                                                    input logic [BSEL_W-1:0]  bsel);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(tf) * SUM_W'(PAGE_BYTES) + SUM_W'(idx) * SUM_W'(ENTRY_BYTES)
            + SUM_W'(bsel);
      return sum[ADDR_W-1:0];
   endfunction

   // Physical address of a data byte, wrapped to memory size
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [FRAME_W-1:0]  frame,
                                                   input logic [OFFSET_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(frame) * SUM_W'(PAGE_BYTES) + SUM_W'(offset);
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/pmm_if.sv =====
// Request and response channel interfaces of the paged MMU.
interface pmm_req_if import pmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PID_W-1:0]    process_id;
   logic [VA_W-1:0]     vaddr;
   logic [DATA_W-1:0]   value;

   modport source (output valid, action, process_id, vaddr, value,
                   input ready);
   modport sink   (input valid, action, process_id, vaddr, value,
                   output ready);
endinterface

interface pmm_rsp_if import pmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   read_data;
   logic [ADDR_W-1:0]   paddr;

   modport source (output valid, status, read_data, paddr,
                   input ready);
   modport sink   (input valid, status, read_data, paddr,
                   output ready);
endinterface

// ===== hw/rtl/pmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/paged_mmu_map_load_store.sv =====
// Paged MMU top level: sequencer around one shared physical memory port.
// A lookup walks the page table entry by entry, up to all four table entries.
// Throughput: one word at a time; the next request is taken once the sequencer
// is idle again, while a finished response may still wait in the output register.
// Reset: synchronous; afterwards a pass clears physical memory, one byte a cycle,
// with ready low; tables and frame use bits clear at once.
module paged_mmu_map_load_store import pmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pmm_req_if.sink          req_bus,
   pmm_rsp_if.source        rsp_bus
);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   clr_ff, clr_in;
   action_type          action_ff, action_in;
   logic [PID_W-1:0]    pid_ff, pid_in;
   logic [VPAGE_W-1:0]  vpage_ff, vpage_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [DATA_W-1:0]   value_ff, value_in;

   logic [FRAME_W-1:0]  tf_ff, tf_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                free_found_ff, free_found_in;
   logic                in_use_ff, in_use_in;
   logic [BSEL_W-1:0]   byte_ff, byte_in;

   logic [FRAME_W-1:0]       table_frame_ff [NUM_PROCESSES];
   logic [FRAME_W-1:0]       table_frame_in [NUM_PROCESSES];
   logic [NUM_PROCESSES-1:0] table_valid_ff, table_valid_in;
   logic [NUM_FRAMES-1:0]    frame_in_use_ff, frame_in_use_in;

   status_type          res_status_ff, res_status_in;
   logic [DATA_W-1:0]   res_rdata_ff, res_rdata_in;
   logic [ADDR_W-1:0]   res_paddr_ff, res_paddr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_rdata_ff, rsp_rdata_in;
   logic [ADDR_W-1:0]   rsp_paddr_ff, rsp_paddr_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [DATA_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [DATA_W-1:0]   mem_rd_data;

   logic                free_any;
   logic [FRAME_W-1:0]  free_frame;
   logic                pid_ok;
   logic [PROC_W-1:0]   pid_idx;
   logic                have_table;
   logic                hit;
   logic                last_entry;
   logic                out_free;
   logic [ADDR_W-1:0]   hit_paddr;

   pmm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_BYTES)
   ) u_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (mem_rd_data)
   );

   // First free frame
   always_comb begin
      free_any   = 1'b0;
      free_frame = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (!frame_in_use_ff[i]) begin
            free_any   = 1'b1;
            free_frame = FRAME_W'(i);
         end
      end
   end

   // Lookup helpers
   assign pid_ok     = 32'(pid_ff) < NUM_PROCESSES;
   assign pid_idx    = pid_ff[PROC_W-1:0];
   assign have_table = pid_ok && table_valid_ff[pid_idx];
   assign hit        = in_use_ff && (mem_rd_data == DATA_W'(vpage_ff));
   assign last_entry = idx_ff == IDX_W'(TABLE_ENTRIES - 1);
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign hit_paddr  = phys_addr(mem_rd_data[FRAME_W-1:0], offset_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(MEM_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_bus.valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (action_ff == ACT_NONE || !pid_ok) begin
               state_in = S_RESPOND;
            end else if (action_ff == ACT_MAP) begin
               if (value_ff > DATA_W'(1)) state_in = S_RESPOND;
               else if (!have_table)      state_in = free_any ? S_ALLOC : S_RESPOND;
               else                       state_in = S_SCAN_USE;
            end else begin
               state_in = have_table ? S_SCAN_USE : S_RESPOND;
            end
         end
         S_ALLOC:      state_in = free_any ? S_WRITE : S_RESPOND;
         S_WRITE: begin
            if (byte_ff == BYTE_USE) state_in = S_RESPOND;
         end
         S_SCAN_USE:   state_in = S_SCAN_PAGE;
         S_SCAN_PAGE:  state_in = S_SCAN_CHECK;
         S_SCAN_CHECK: begin
            if (hit)             state_in = S_HIT;
            else if (last_entry) state_in = S_MISS;
            else                 state_in = S_SCAN_USE;
         end
         S_MISS: begin
            if (action_ff == ACT_MAP && free_found_ff && free_any) state_in = S_WRITE;
            else                                                    state_in = S_RESPOND;
         end
         S_HIT:        state_in = S_HIT_FRAME;
         S_HIT_FRAME: begin
            case (action_ff)
               ACT_STORE: state_in = S_STORE_PROT;
               ACT_LOAD:  state_in = S_LOAD_DATA;
               default:   state_in = S_RESPOND;
            endcase
         end
         S_STORE_PROT: state_in = S_RESPOND;
         S_LOAD_DATA:  state_in = S_RESPOND;
         S_RESPOND: begin
            if (out_free) state_in = S_IDLE;
         end
         default:      state_in = S_CLEAR;
      endcase
   end

   // Datapath, memory port and handshake outputs
   always_comb begin
      clr_in          = clr_ff;
      action_in       = action_ff;
      pid_in          = pid_ff;
      vpage_in        = vpage_ff;
      offset_in       = offset_ff;
      value_in        = value_ff;
      tf_in           = tf_ff;
      frame_in        = frame_ff;
      idx_in          = idx_ff;
      free_idx_in     = free_idx_ff;
      free_found_in   = free_found_ff;
      in_use_in       = in_use_ff;
      byte_in         = byte_ff;
      table_frame_in  = table_frame_ff;
      table_valid_in  = table_valid_ff;
      frame_in_use_in = frame_in_use_ff;
      res_status_in   = res_status_ff;
      res_rdata_in    = res_rdata_ff;
      res_paddr_in    = res_paddr_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_rdata_in    = rsp_rdata_ff;
      rsp_paddr_in    = rsp_paddr_ff;
      ram_we          = 1'b0;
      ram_waddr       = entry_addr(tf_ff, idx_ff, byte_ff);
      ram_wdata       = '0;
      ram_raddr       = '0;
      req_bus.ready   = 1'b0;

      unique case (state_ff)
         // Zero one memory byte per cycle
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         // Capture the request word
         S_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               action_in     = action_type'(req_bus.action);
               pid_in        = req_bus.process_id;
               vpage_in      = req_bus.vaddr[VA_W-1:OFFSET_W];
               offset_in     = req_bus.vaddr[OFFSET_W-1:0];
               value_in      = req_bus.value;
               idx_in        = '0;
               byte_in       = '0;
               free_found_in = 1'b0;
               res_status_in = ST_OK;
               res_rdata_in  = '0;
               res_paddr_in  = '0;
            end
         end
         // Early outcomes and page-table allocation
         S_DISPATCH: begin
            tf_in = table_frame_ff[pid_idx];
            if (action_ff == ACT_NONE) begin
               res_status_in = ST_OK;
            end else if (!pid_ok) begin
               res_status_in = ST_NO_TABLE;
            end else if (action_ff == ACT_MAP) begin
               if (value_ff > DATA_W'(1)) begin
                  res_status_in = ST_BAD_PROT;
               end else if (!have_table) begin
                  if (!free_any) begin
                     res_status_in = ST_NO_MEMORY;
                  end else begin
                     frame_in_use_in[free_frame] = 1'b1;
                     table_valid_in[pid_idx]     = 1'b1;
                     table_frame_in[pid_idx]     = free_frame;
                     tf_in                       = free_frame;
                  end
               end
            end else if (!have_table) begin
               res_status_in = ST_NO_TABLE;
            end
         end
         // Data frame for the first entry of a new table
         S_ALLOC: begin
            if (free_any) begin
               frame_in_use_in[free_frame] = 1'b1;
               frame_in                    = free_frame;
            end else begin
               res_status_in = ST_NO_MEMORY;
            end
         end
         // Write the four entry bytes
         S_WRITE: begin
            ram_we  = 1'b1;
            byte_in = byte_ff + BSEL_W'(1);
            case (byte_ff)
               BYTE_PAGE:  ram_wdata = DATA_W'(vpage_ff);
               BYTE_FRAME: ram_wdata = DATA_W'(frame_ff);
               BYTE_PROT:  ram_wdata = value_ff;
               default:    ram_wdata = DATA_W'(1);
            endcase
            if (byte_ff == BYTE_USE) begin
               res_status_in = ST_OK;
               res_paddr_in  = phys_addr(frame_ff, offset_ff);
            end
         end
         // Table walk: in-use byte, then page byte
         S_SCAN_USE: begin
            ram_raddr = entry_addr(tf_ff, idx_ff, BYTE_USE);
         end
         S_SCAN_PAGE: begin
            in_use_in = mem_rd_data != '0;
            if (mem_rd_data == '0 && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            ram_raddr = entry_addr(tf_ff, idx_ff, BYTE_PAGE);
         end
         S_SCAN_CHECK: begin
            if (!hit && !last_entry) idx_in = idx_ff + IDX_W'(1);
         end
         // No in-use entry for the page
         S_MISS: begin
            if (action_ff == ACT_MAP) begin
               if (!free_found_ff) begin
                  res_status_in = ST_TABLE_FULL;
               end else if (!free_any) begin
                  res_status_in = ST_NO_MEMORY;
               end else begin
                  frame_in_use_in[free_frame] = 1'b1;
                  frame_in                    = free_frame;
                  idx_in                      = free_idx_ff;
                  byte_in                     = '0;
               end
            end else begin
               res_status_in = ST_NO_ENTRY;
            end
         end
         // Entry found: fetch its frame, remap rewrites protection
         S_HIT: begin
            ram_raddr = entry_addr(tf_ff, idx_ff, BYTE_FRAME);
            if (action_ff == ACT_MAP) begin
               ram_we    = 1'b1;
               ram_waddr = entry_addr(tf_ff, idx_ff, BYTE_PROT);
               ram_wdata = value_ff;
            end
         end
         S_HIT_FRAME: begin
            frame_in = mem_rd_data[FRAME_W-1:0];
            case (action_ff)
               ACT_MAP: begin
                  res_status_in = ST_PROT_UPDATED;
                  res_paddr_in  = hit_paddr;
               end
               ACT_LOAD:  ram_raddr = hit_paddr;
               default:   ram_raddr = entry_addr(tf_ff, idx_ff, BYTE_PROT);
            endcase
         end
         // Store goes through only on a writable page
         S_STORE_PROT: begin
            if (mem_rd_data == '0) begin
               res_status_in = ST_WRITE_PROT;
            end else begin
               ram_we        = 1'b1;
               ram_waddr     = phys_addr(frame_ff, offset_ff);
               ram_wdata     = value_ff;
               res_status_in = ST_OK;
               res_paddr_in  = phys_addr(frame_ff, offset_ff);
            end
         end
         S_LOAD_DATA: begin
            res_status_in = ST_OK;
            res_rdata_in  = mem_rd_data;
            res_paddr_in  = phys_addr(frame_ff, offset_ff);
         end
         // Hand the result to the output register once it is free
         S_RESPOND: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rdata_in  = res_rdata_ff;
               rsp_paddr_in  = res_paddr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         table_valid_ff  <= '0;
         frame_in_use_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ff          <= clr_in;
         table_valid_ff  <= table_valid_in;
         frame_in_use_ff <= frame_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      action_ff      <= action_in;
      pid_ff         <= pid_in;
      vpage_ff       <= vpage_in;
      offset_ff      <= offset_in;
      value_ff       <= value_in;
      tf_ff          <= tf_in;
      frame_ff       <= frame_in;
      idx_ff         <= idx_in;
      free_idx_ff    <= free_idx_in;
      free_found_ff  <= free_found_in;
      in_use_ff      <= in_use_in;
      byte_ff        <= byte_in;
      table_frame_ff <= table_frame_in;
      res_status_ff  <= res_status_in;
      res_rdata_ff   <= res_rdata_in;
      res_paddr_ff   <= res_paddr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_rdata_ff   <= rsp_rdata_in;
      rsp_paddr_ff   <= rsp_paddr_in;
   end

   // Response channel
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.read_data = rsp_rdata_ff;
   assign rsp_bus.paddr     = rsp_paddr_ff;

   // No request is taken while memory is being cleared
   a_clear_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_bus.ready)
      else $error("request accepted during memory clear");

   // Frames are never released
   a_frames_kept: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ((frame_in_use_ff & $past(frame_in_use_ff)) == $past(frame_in_use_ff)))
      else $error("frame in-use bit dropped");

   // Page tables are never released
   a_tables_kept: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         ((table_valid_ff & $past(table_valid_ff)) == $past(table_valid_ff)))
      else $error("page table valid bit dropped");

   // Every page table owns a frame of its own
   a_table_frames: assert property (@(posedge clock) disable iff (reset)
      $countones(frame_in_use_ff) >= $countones(table_valid_ff))
      else $error("more page tables than frames in use");

endmodule
